// File: rtl/subset_sum_balance_traceback_macros.svh
// assertion macros for the subset-sum balance checker
`ifndef SUBSET_SUM_BALANCE_TRACEBACK_MACROS_SVH
`define SUBSET_SUM_BALANCE_TRACEBACK_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SSBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SSBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssbt_pkg.sv
// package: field widths and controller/datapath interface types
`timescale 1ns / 1ps

package ssbt_pkg;

    localparam int VALUE_W = 8;
    localparam int INDEX_W = 7;
    localparam int BEST_W  = 8;
    localparam int TOTAL_W = 14;

    typedef struct packed {
        logic load;
        logic init;
        logic search_dec;
        logic trace_start;
        logic rd;
        logic step_skip;
        logic emit_take;
        logic emit_empty;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic best_zero;
        logic best_hit;
        logic row_bit;
        logic take_final;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/subset_sum_balance_traceback.sv
// each value word is taken with a shift-or of the reach row plus one memory write
// after the closing word: the total is halved, then the best-sum search steps down
//   one sum at a time from min(total/2, SUM_LIMIT) to the first reachable sum or zero,
//   then items are walked back newest first (memory read, then decide), waiting on any output stall
// the input stalls from the closing word until its last result is loaded into the output register
// reset: synchronous, active low; clears count, total, overflow flag, reach row and output valid
`timescale 1ns / 1ps

// top level: subset-sum balance with traceback of the chosen items
module subset_sum_balance_traceback import ssbt_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int SUM_LIMIT = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    // result word channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [INDEX_W-1:0] o_item_index,
    output logic [BEST_W-1:0]  o_best_sum,
    output logic [TOTAL_W-1:0] o_total_sum,
    output logic               o_over_limit,
    output logic               o_run_end
);

    // command and status between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle/load, halve, search, read, decide, empty-set result
    ssbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath: the current reach row lives in flops, earlier rows and the
    // weights in a single-port memory; the result word sits in an output
    // register so loading of the next set can start while it waits
    ssbt_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .SUM_LIMIT (SUM_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_item_index (o_item_index),
        .o_best_sum   (o_best_sum),
        .o_total_sum  (o_total_sum),
        .o_over_limit (o_over_limit),
        .o_run_end    (o_run_end)
    );

endmodule

// File: rtl/ssbt_ctrl.sv
// controller state machine: load, best-sum search and traceback sequencing
`timescale 1ns / 1ps

module ssbt_ctrl import ssbt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SEARCH,
        S_READ,
        S_EVAL,
        S_EMPTY
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;
    logic    w_accept;

    assign o_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept = i_valid && !o_stall;
    assign o_cmd    = w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                w_cmd.init = 1'b1;
                n_state    = S_SEARCH;
            end
            S_SEARCH: begin
                priority if (i_sts.best_zero) begin
                    w_cmd.trace_start = 1'b1;
                    n_state           = S_EMPTY;
                end else if (i_sts.best_hit) begin
                    w_cmd.trace_start = 1'b1;
                    n_state           = S_READ;
                end else begin
                    w_cmd.search_dec = 1'b1;
                end
            end
            S_READ: begin
                w_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                priority if (i_sts.row_bit) begin
                    // sum still reachable without this item: leave it out
                    w_cmd.step_skip = 1'b1;
                    n_state         = S_READ;
                end else if (i_sts.out_free) begin
                    w_cmd.emit_take = 1'b1;
                    if (i_sts.take_final) begin
                        w_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end else begin
                    // output register still held: wait
                    n_state = S_EVAL;
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_empty = 1'b1;
                    w_cmd.clear      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/ssbt_dp.sv
// datapath: reach row, row/weight memory, search and traceback registers, output word
`timescale 1ns / 1ps

module ssbt_dp import ssbt_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int SUM_LIMIT = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [INDEX_W-1:0] o_item_index,
    output logic [BEST_W-1:0]  o_best_sum,
    output logic [TOTAL_W-1:0] o_total_sum,
    output logic               o_over_limit,
    output logic               o_run_end
);

    localparam int ROW_W  = SUM_LIMIT + 1;
    localparam int SUM_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int ENT_W  = ROW_W + VALUE_W;
    localparam int EXT_W  = ROW_W + (1 << VALUE_W);
    localparam int DIF_W  = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;

    // entry k holds row k of the reach table and the weight of item k+1
    logic [ENT_W-1:0]   r_mem [MAX_ITEMS];

    logic [ROW_W-1:0]   r_row;
    logic [TOTAL_W-1:0] r_total;
    logic               r_over;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_best;
    logic [SUM_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_i;
    logic [ROW_W-1:0]   r_rd_row;
    logic [VALUE_W-1:0] r_rd_w;

    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [BEST_W-1:0]  r_out_best;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_over;
    logic               r_out_end;

    logic [EXT_W-1:0]   w_ext;
    logic [ROW_W-1:0]   w_next_row;
    logic               w_ovf;
    logic               w_full;
    logic               w_load;
    logic [TOTAL_W-1:0] w_half;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [DIF_W-1:0]   w_diff;
    logic [SUM_W-1:0]   w_j_next;
    logic               w_out_free;

    // shift-or of the reach row; bits pushed past the limit flag overflow
    assign w_ext      = EXT_W'(r_row) << i_value;
    assign w_next_row = r_row | w_ext[ROW_W-1:0];
    assign w_ovf      = |w_ext[EXT_W-1:ROW_W];
    assign w_full     = (r_count == CNT_W'(MAX_ITEMS));
    assign w_load     = i_cmd.load && !w_full;

    assign w_half     = r_total >> 1;
    assign w_rd_addr  = ADDR_W'(r_i - CNT_W'(1));
    assign w_diff     = DIF_W'(r_j) - DIF_W'(r_rd_w);
    assign w_j_next   = (DIF_W'(r_j) >= DIF_W'(r_rd_w)) ? w_diff[SUM_W-1:0] : '0;
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_sts.best_zero  = (r_best == '0);
    assign o_sts.best_hit   = r_row[r_best];
    assign o_sts.row_bit    = r_rd_row[r_j];
    assign o_sts.take_final = (w_j_next == '0) || (r_i == CNT_W'(1));
    assign o_sts.out_free   = w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[r_count[ADDR_W-1:0]] <= {r_row, i_value};
        end
        if (i_cmd.rd) begin
            {r_rd_row, r_rd_w} <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= ROW_W'(1);
            r_total     <= '0;
            r_over      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_row   <= w_next_row;
                r_total <= r_total + TOTAL_W'(i_value);
                r_over  <= r_over | w_ovf;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_row   <= ROW_W'(1);
                r_total <= '0;
                r_over  <= 1'b0;
                r_count <= '0;
            end
            if (i_cmd.emit_take || i_cmd.emit_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_best <= (w_half > TOTAL_W'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT) : SUM_W'(w_half);
        end else if (i_cmd.search_dec) begin
            r_best <= r_best - SUM_W'(1);
        end
        if (i_cmd.trace_start) begin
            r_j <= r_best;
            r_i <= r_count;
        end else if (i_cmd.step_skip) begin
            r_i <= r_i - CNT_W'(1);
        end else if (i_cmd.emit_take) begin
            r_i <= r_i - CNT_W'(1);
            r_j <= w_j_next;
        end
        if (i_cmd.emit_take) begin
            r_out_index <= INDEX_W'(r_i);
            r_out_best  <= BEST_W'(r_best);
            r_out_total <= r_total;
            r_out_over  <= r_over;
            r_out_end   <= o_sts.take_final;
        end else if (i_cmd.emit_empty) begin
            r_out_index <= '0;
            r_out_best  <= BEST_W'(r_best);
            r_out_total <= r_total;
            r_out_over  <= r_over;
            r_out_end   <= 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_item_index = r_out_index;
    assign o_best_sum   = r_out_best;
    assign o_total_sum  = r_out_total;
    assign o_over_limit = r_out_over;
    assign o_run_end    = r_out_end;

endmodule

// File: rtl/ssbt_checker.sv
// port-level checker for the subset-sum balance block, with its bind
`timescale 1ns / 1ps
`include "subset_sum_balance_traceback_macros.svh"

module ssbt_checker import ssbt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_last,
    input logic               o_valid,
    input logic               i_stall,
    input logic [INDEX_W-1:0] o_item_index,
    input logic [BEST_W-1:0]  o_best_sum,
    input logic [TOTAL_W-1:0] o_total_sum,
    input logic               o_over_limit,
    input logic               o_run_end
);

    // stalled result word holds
    `SSBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rst_n && o_valid && i_stall, o_valid && $stable(o_item_index) && $stable(o_best_sum) && $stable(o_total_sum) && $stable(o_over_limit) && $stable(o_run_end), "result word changed under stall")

    // a closing word makes the block busy in the next cycle
    `SSBT_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_rst_n && i_valid && !o_stall && i_last, o_stall, "input not stalled after closing word")

    // index zero only as the single, final result
    `SSBT_ASSERT_NOW(a_zero_is_final, i_clk, i_rst_n, o_valid && (o_item_index == '0), o_run_end, "index zero without run end")

    // within a set the chosen indexes fall
    `SSBT_ASSERT_NEXT(a_index_falls, i_clk, i_rst_n, i_rst_n && o_valid && !i_stall && !o_run_end, !o_valid || (o_item_index < $past(o_item_index)), "item indexes not falling")

endmodule

bind subset_sum_balance_traceback ssbt_checker u_ssbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_last       (i_last),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_item_index (o_item_index),
    .o_best_sum   (o_best_sum),
    .o_total_sum  (o_total_sum),
    .o_over_limit (o_over_limit),
    .o_run_end    (o_run_end)
);

// File: bench/testbench.sv
// self-checking bench for the subset-sum balance block with traceback
`timescale 1ns / 1ps

module testbench;
    import ssbt_pkg::*;

    localparam int MAX_ITEMS     = 64;
    localparam int SUM_LIMIT     = 128;
    localparam int RANDOM_WORDS  = 105;
    // search plus a full walk back, with slack
    localparam int SETTLE_CYCLES = SUM_LIMIT + 2 * MAX_ITEMS + 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // one result word, fields at the port widths
    typedef struct packed {
        logic [INDEX_W-1:0] item_index;
        logic [BEST_W-1:0]  best_sum;
        logic [TOTAL_W-1:0] total_sum;
        logic               over_limit;
        logic               run_end;
    } t_balance_word;

    // one row of the directed table: value word plus an optional typed-in answer
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        t_balance_word      want;
    } t_plan_row;

    localparam t_balance_word NO_WANT = '0;
    localparam int PLAN_ROWS = 23;

    // directed part: extremes, empty choice, overflow, zero weights
    t_plan_row plan [0:PLAN_ROWS-1] = '{
        // lone zero: nothing taken
        '{8'd0,   1'b1, 1'b1, '{7'd0, 8'd0, 14'd0,   1'b0, 1'b1}},
        // lone max legal weight: half is not reachable
        '{8'd128, 1'b1, 1'b1, '{7'd0, 8'd0, 14'd128, 1'b0, 1'b1}},
        // all ones: weight above the limit, flagged
        '{8'd255, 1'b1, 1'b1, '{7'd0, 8'd0, 14'd255, 1'b1, 1'b1}},
        '{8'd1,   1'b0, 1'b0, NO_WANT},
        '{8'd1,   1'b1, 1'b0, NO_WANT},
        '{8'd3,   1'b0, 1'b0, NO_WANT},
        '{8'd5,   1'b0, 1'b0, NO_WANT},
        '{8'd2,   1'b0, 1'b0, NO_WANT},
        '{8'd6,   1'b1, 1'b0, NO_WANT},
        // two large weights: second sum crosses the limit
        '{8'd100, 1'b0, 1'b0, NO_WANT},
        '{8'd100, 1'b1, 1'b0, NO_WANT},
        // half capped at the limit exactly
        '{8'd128, 1'b0, 1'b0, NO_WANT},
        '{8'd128, 1'b1, 1'b0, NO_WANT},
        // alternating bit patterns, then a zero closing word
        '{8'd170, 1'b0, 1'b0, NO_WANT},
        '{8'd85,  1'b0, 1'b0, NO_WANT},
        '{8'd0,   1'b1, 1'b0, NO_WANT},
        // all-zero set: nothing taken
        '{8'd0,   1'b0, 1'b1, NO_WANT},
        '{8'd0,   1'b0, 1'b1, NO_WANT},
        '{8'd0,   1'b1, 1'b1, '{7'd0, 8'd0, 14'd0,   1'b0, 1'b1}},
        '{8'd64,  1'b0, 1'b0, NO_WANT},
        '{8'd64,  1'b0, 1'b0, NO_WANT},
        '{8'd1,   1'b0, 1'b0, NO_WANT},
        '{8'd127, 1'b1, 1'b0, NO_WANT}
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_last  = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [INDEX_W-1:0] o_item_index;
    logic [BEST_W-1:0]  o_best_sum;
    logic [TOTAL_W-1:0] o_total_sum;
    logic               o_over_limit;
    logic               o_run_end;

    // idle rates in percent, changed between phases while nothing is in flight
    int send_idle_pct = 24;
    int stall_pct     = 51;

    // bench copy of the block state
    logic [SUM_LIMIT:0] reach_rows [0:MAX_ITEMS];
    logic [VALUE_W-1:0] held_weights [0:MAX_ITEMS-1];
    int                 held_count = 0;
    logic [TOTAL_W-1:0] set_total  = '0;
    logic               sum_dropped = 1'b0;

    // answers still owed by the block, oldest first
    t_balance_word owed_words [$];

    int mismatches = 0;
    int cycles     = 0;

    subset_sum_balance_traceback #(
        .MAX_ITEMS(MAX_ITEMS),
        .SUM_LIMIT(SUM_LIMIT)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item_index (o_item_index),
        .o_best_sum   (o_best_sum),
        .o_total_sum  (o_total_sum),
        .o_over_limit (o_over_limit),
        .o_run_end    (o_run_end)
    );

    always #10 i_clk = ~i_clk;

    // load one weight into the bench state; on the closing word, search and trace back
    task automatic balance_word(input logic [VALUE_W-1:0] w, input logic last,
                                input bit owe_results);
        logic [SUM_LIMIT:0] row;
        t_balance_word      ans;
        int                 best;
        int                 j;
        int                 i;
        int                 taken;
        // full set: the weight is dropped but a closing flag still counts
        if (held_count < MAX_ITEMS) begin
            row = reach_rows[held_count];
            for (int s = 0; s <= SUM_LIMIT; s++) begin
                if (row[s] && s + int'(w) > SUM_LIMIT)
                    sum_dropped = 1'b1;
            end
            // sums pushed past the limit fall off the top of the row
            reach_rows[held_count + 1] = row | (row << w);
            held_weights[held_count] = w;
            held_count++;
            set_total = set_total + TOTAL_W'(w);
        end
        if (!last)
            return;

        best = int'(set_total) / 2;
        if (best > SUM_LIMIT)
            best = SUM_LIMIT;
        while (best > 0 && !reach_rows[held_count][best])
            best--;

        // walk back from the newest item, skipping any item the sum can do without
        j = best;
        taken = 0;
        for (i = held_count; i >= 1 && j > 0; i--) begin
            if (!reach_rows[i - 1][j]) begin
                j = (j >= int'(held_weights[i - 1])) ? j - int'(held_weights[i - 1]) : 0;
                ans = '{INDEX_W'(i), BEST_W'(best), set_total, sum_dropped,
                        (j == 0 || i == 1)};
                if (owe_results)
                    owed_words = {owed_words, ans};
                taken++;
            end
        end
        if (taken == 0 && owe_results) begin
            ans = '{'0, BEST_W'(best), set_total, sum_dropped, 1'b1};
            owed_words = {owed_words, ans};
        end

        held_count  = 0;
        set_total   = '0;
        sum_dropped = 1'b0;
    endtask

    // present one value word, idling at random first, and hold it until taken
    task automatic send_word(input logic [VALUE_W-1:0] w, input logic last,
                             input bit typed, input t_balance_word want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= w;
        i_last  <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // taken at this edge
        balance_word(w, last, !typed);
        if (typed && last)
            owed_words = {owed_words, want};
    endtask

    // sender holds off until every owed answer has come back
    task automatic hold_until_empty();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_words.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly small weights so sets stay balanceable, some up to the field limit
    function automatic logic [VALUE_W-1:0] pick_weight(input bit light);
        int roll;
        roll = $urandom_range(0, 99);
        if (light)
            return (roll < 90) ? VALUE_W'($urandom_range(0, 4))
                               : VALUE_W'($urandom_range(0, 40));
        if (roll < 60)
            return VALUE_W'($urandom_range(0, 40));
        if (roll < 85)
            return VALUE_W'($urandom_range(0, 128));
        return VALUE_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input t_balance_word want,
                                   input t_balance_word got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s: expected idx %0d best %0d total %0d over %0b end %0b,",
                     what, want.item_index, want.best_sum, want.total_sum,
                     want.over_limit, want.run_end,
                     " got idx %0d best %0d total %0d over %0b end %0b",
                     got.item_index, got.best_sum, got.total_sum,
                     got.over_limit, got.run_end);
    endtask

    // result side: check each taken word against the oldest owed answer, then pick a stall
    always @(posedge i_clk) begin : result_check
        t_balance_word got;
        t_balance_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_item_index, o_best_sum, o_total_sum, o_over_limit, o_run_end};
            if (owed_words.size() == 0) begin
                report_mismatch("unexpected word", NO_WANT, got);
            end else begin
                want = owed_words.pop_front();
                if (got.item_index !== want.item_index || got.best_sum !== want.best_sum ||
                    got.total_sum !== want.total_sum || got.over_limit !== want.over_limit ||
                    got.run_end !== want.run_end)
                    report_mismatch("mismatch", want, got);
            end
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("subset_sum_balance_traceback regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        int set_len;
        reach_rows[0] = '0;
        reach_rows[0][0] = 1'b1;

        // reset held low from the start, then released once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the first idle mix
        for (int r = 0; r < PLAN_ROWS; r++)
            send_word(plan[r].value, plan[r].last, plan[r].typed, plan[r].want);
        hold_until_empty();

        // random sets in three idle mixes; the last mix opens with an overfull set
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 51 : 0;
            stall_pct     = (phase == 0) ? 51 : (phase == 1) ? 24 : 0;
            if (phase == 2) begin
                // words past the capacity are ignored, the closing one still ends the set
                set_len = MAX_ITEMS + $urandom_range(1, 4);
                for (int k = 0; k < set_len; k++)
                    send_word(pick_weight(1'b1), k == set_len - 1, 1'b0, NO_WANT);
                sent += MAX_ITEMS;
            end
            while (sent < (phase + 1) * RANDOM_WORDS / 3 + ((phase == 2) ? MAX_ITEMS : 0)) begin
                set_len = $urandom_range(1, 8);
                for (int k = 0; k < set_len; k++)
                    send_word(pick_weight(1'b0), k == set_len - 1, 1'b0, NO_WANT);
                sent += set_len;
            end
            hold_until_empty();
        end

        // let any stray words show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed_words.size() == 0) begin
            $display("subset_sum_balance_traceback regression: pass");
        end else begin
            $display("subset_sum_balance_traceback regression: fail");
        end
        $finish;
    end

endmodule
